[rtl/core/ubxfc_pkg.sv]
// shared types, register indexes and reset values of the frame checker
package ubxfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned STAT_W = 3;

    // register indexes on the configuration channel
    localparam logic [IDX_W-1:0] CFG_SYNC_FIRST     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SYNC_SECOND    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MESSAGE_CLASS  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MESSAGE_ID     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd4;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST     = 8'd181;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND    = 8'd98;
    localparam logic [BYTE_W-1:0] RST_MESSAGE_CLASS  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_MESSAGE_ID     = 8'd6;
    localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH = 16'd52;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_SYNC     = 3'd2,
        ST_CLASS_ID = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] message_class;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_length;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } t_in_item;

endpackage

[rtl/core/ubxfc_if.sv]
// channel interfaces: byte input, result output and configuration write
interface ubxfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ubxfc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] offset;
    logic [2:0]  status;
    logic        frame_last;

    modport source (output valid, output kind, output payload_byte, output offset,
                    output status, output frame_last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input offset,
                    input status, input frame_last, output ready);
endinterface

interface ubxfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ubxfc_cfg_regs.sv]
// configuration register file of the frame checker
module ubxfc_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ubxfc_cfg_if.sink       i_cfg,
    output ubxfc_pkg::t_cfg o_cfg
);
    import ubxfc_pkg::*;

    t_cfg r_cfg;
    logic w_write;

    assign i_cfg.ready = 1'b1;
    assign w_write     = i_cfg.valid & i_cfg.ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= RST_SYNC_FIRST;
            r_cfg.sync_second    <= RST_SYNC_SECOND;
            r_cfg.message_class  <= RST_MESSAGE_CLASS;
            r_cfg.message_id     <= RST_MESSAGE_ID;
            r_cfg.payload_length <= RST_PAYLOAD_LENGTH;
        end else if (w_write) begin
            case (i_cfg.index)
                CFG_SYNC_FIRST:     r_cfg.sync_first     <= i_cfg.data[BYTE_W-1:0];
                CFG_SYNC_SECOND:    r_cfg.sync_second    <= i_cfg.data[BYTE_W-1:0];
                CFG_MESSAGE_CLASS:  r_cfg.message_class  <= i_cfg.data[BYTE_W-1:0];
                CFG_MESSAGE_ID:     r_cfg.message_id     <= i_cfg.data[BYTE_W-1:0];
                CFG_PAYLOAD_LENGTH: r_cfg.payload_length <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/ubxfc_in_reg.sv]
// input register stage holding one byte request
module ubxfc_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ubxfc_in_if.sink            i_in,
    input  logic                i_advance,
    output logic                o_valid,
    output ubxfc_pkg::t_in_item o_item
);
    import ubxfc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    // free when empty or when the held byte moves on this cycle
    assign i_in.ready = ~r_valid | i_advance;
    assign w_accept   = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.buffer_end <= i_in.buffer_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/ubxfc_parser.sv]
// frame state, fletcher checksum and result register
module ubxfc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ubxfc_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  ubxfc_pkg::t_in_item i_item,
    output logic                o_advance,
    ubxfc_out_if.source         o_res
);
    import ubxfc_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO,
        PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B, PH_SKIP
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum_a, n_sum_a;
    logic [BYTE_W-1:0] r_sum_b, n_sum_b;
    logic [LEN_W-1:0]  r_byte_count, n_byte_count;
    logic [BYTE_W-1:0] r_length_low, n_length_low;
    logic [BYTE_W-1:0] r_check_a, n_check_a;

    logic              r_out_valid;
    logic              r_kind;
    logic [BYTE_W-1:0] r_payload_byte;
    logic [LEN_W-1:0]  r_offset;
    t_status           r_status;

    logic              w_has_status;
    logic              w_has_payload;
    t_status           w_status;
    logic [BYTE_W-1:0] w_add_a;
    logic [BYTE_W-1:0] w_add_b;
    logic              w_last_payload;
    logic [BYTE_W-1:0] b;

    assign b         = i_item.data_byte;
    assign o_advance = i_valid & (~r_out_valid | o_res.ready);

    assign w_add_a        = r_sum_a + b;
    assign w_add_b        = r_sum_b + w_add_a;
    assign w_last_payload = ({1'b0, r_byte_count} + 17'd1) >= {1'b0, i_cfg.payload_length};

    always_comb begin
        n_phase       = r_phase;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_byte_count  = r_byte_count;
        n_length_low  = r_length_low;
        n_check_a     = r_check_a;
        w_has_status  = 1'b0;
        w_has_payload = 1'b0;
        w_status      = ST_OK;
        case (r_phase)
            PH_SYNC1: begin
                if (b != i_cfg.sync_first) begin
                    w_has_status = 1'b1;
                    w_status     = ST_SYNC;
                end else begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (b != i_cfg.sync_second) begin
                    w_has_status = 1'b1;
                    w_status     = ST_SYNC;
                end else begin
                    n_phase = PH_CLASS;
                end
            end
            PH_CLASS: begin
                if (b != i_cfg.message_class) begin
                    w_has_status = 1'b1;
                    w_status     = ST_CLASS_ID;
                end else begin
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = PH_ID;
                end
            end
            PH_ID: begin
                if (b != i_cfg.message_id) begin
                    w_has_status = 1'b1;
                    w_status     = ST_CLASS_ID;
                end else begin
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_length_low = b;
                n_sum_a      = w_add_a;
                n_sum_b      = w_add_b;
                n_phase      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                if ({b, r_length_low} != i_cfg.payload_length) begin
                    w_has_status = 1'b1;
                    w_status     = ST_LENGTH;
                end else begin
                    n_byte_count = '0;
                    // empty payload goes straight to the checksum
                    n_phase = (i_cfg.payload_length == '0) ? PH_CK_A : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum_a       = w_add_a;
                n_sum_b       = w_add_b;
                w_has_payload = 1'b1;
                if (w_last_payload) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_byte_count = r_byte_count + 16'd1;
                end
            end
            PH_CK_A: begin
                n_check_a = b;
                n_phase   = PH_CK_B;
            end
            PH_CK_B: begin
                w_has_status = 1'b1;
                w_status     = (r_check_a == r_sum_a && b == r_sum_b) ? ST_OK : ST_CHECKSUM;
            end
            default: begin
            end
        endcase

        if (w_has_status) begin
            n_phase = PH_SKIP;
        end

        // buffer end: report short unless a status is already out, then clear
        if (i_item.buffer_end) begin
            if (n_phase != PH_SKIP) begin
                w_has_status  = 1'b1;
                w_has_payload = 1'b0;
                w_status      = ST_SHORT;
            end
            n_phase      = PH_SYNC1;
            n_sum_a      = '0;
            n_sum_b      = '0;
            n_byte_count = '0;
            n_length_low = '0;
            n_check_a    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC1;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_byte_count <= '0;
            r_length_low <= '0;
            r_check_a    <= '0;
            r_out_valid  <= 1'b0;
        end else if (o_advance) begin
            r_phase      <= n_phase;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_byte_count <= n_byte_count;
            r_length_low <= n_length_low;
            r_check_a    <= n_check_a;
            r_out_valid  <= w_has_status | w_has_payload;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_kind         <= w_has_status;
            r_payload_byte <= w_has_status ? '0 : b;
            r_offset       <= w_has_status ? '0 : r_byte_count;
            r_status       <= w_has_status ? w_status : ST_OK;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.payload_byte = r_payload_byte;
    assign o_res.offset       = r_offset;
    assign o_res.status       = r_status;
    assign o_res.frame_last   = r_kind;

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind |-> r_payload_byte == '0 && r_offset == '0)
        else $error("status result carries payload fields");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_kind |-> r_status == ST_OK)
        else $error("payload result carries a status code");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && i_item.buffer_end |=>
            r_phase == PH_SYNC1 && r_sum_a == '0 && r_sum_b == '0 && r_byte_count == '0)
        else $error("frame state not cleared after buffer end");

    a_status_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && w_has_status |=> r_phase == PH_SKIP || r_phase == PH_SYNC1)
        else $error("bytes not ignored after a status");

endmodule

[rtl/core/ubx_frame_checker_top.sv]
// top level of the ubx frame checker
//
// checks one frame per receive buffer, one byte request at a time on i_in
// (data_byte, buffer_end marks the last byte of the buffer). each payload
// byte comes out on o_res with its offset (kind 0); one status result per
// buffer (kind 1, frame_last 1) reports ok, short, sync, class/id, length
// or checksum, after which bytes give no result until buffer end.
// i_cfg writes the five registers by index (sync bytes, class, id, payload
// length); it is always ready. the user must see that it is written only
// while the block is idle; the block itself does not enforce this. a byte
// request passes an input register and the parse/checksum logic into the
// result register.
// throughput is one byte per cycle while o_res does not stall.
// a byte request is taken while an earlier result waits, as long as the
// input register is free or moving on; if o_res stalls, at most one byte
// is held and then i_in.ready drops until the receiver takes the result.
// synchronous reset clears the frame state, restores register defaults
// and empties both stages.
module ubx_frame_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ubxfc_in_if.sink    i_in,
    ubxfc_cfg_if.sink   i_cfg,
    ubxfc_out_if.source o_res
);
    import ubxfc_pkg::*;

    t_cfg     w_cfg;
    t_in_item w_item;
    logic     w_item_valid;
    logic     w_advance;

    // register file, taken directly by the parser
    ubxfc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input register, refilled in the same cycle the held byte advances
    ubxfc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    // phase tracking, fletcher sums and the result register
    ubxfc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_item_valid),
        .i_item    (w_item),
        .o_advance (w_advance),
        .o_res     (o_res)
    );

endmodule
